// ===== src/bdpa_pkg.sv =====
`default_nettype none

package bdpa_pkg;

   localparam int DEFAULT_ADDR_WIDTH = 32;

   localparam int BYTE_WIDTH   = 8;
   localparam int SIZE_WIDTH   = 32;
   localparam int LEN_WIDTH    = 31;
   localparam int WORD_WIDTH   = 64;
   localparam int COUNT_WIDTH  = 5;
   localparam int OUT_ADDR_WIDTH = 32;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_DIFF,
      PH_EXTRA,
      PH_DONE,
      PH_ERROR,
      PH_HEADER_BAD
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_RUN,
      STATUS_DONE,
      STATUS_CORRUPT
   } status_type;

   typedef enum logic [1:0] {
      WORD_DIFF,
      WORD_EXTRA,
      WORD_SEEK
   } word_sel_type;

endpackage

`default_nettype wire

// ===== src/binary_delta_patch_applier.sv =====
`default_nettype none

// Rebuilds a new file from an old file and a decompressed patch stream, one patch
// byte per word. Each record opens with three 8-byte little-endian sign-magnitude
// control words (diff length, extra length, seek); diff bytes are added to the old
// byte mod 256, extra bytes are copied, and the old position then moves by the seek,
// wrapping at ADDR_WIDTH bits. Every request word must carry the old-file byte at the
// rsp_old_address of the previous response (address 0 after reset). Exactly one
// response word per request word; the block takes one word per cycle, with a single
// registered response stage, so req_ready is low only while a response waits.
// Once status reads complete or corrupt it stays so until reset. Write csr_new_size
// only while no word is in flight.
module binary_delta_patch_applier #(
   parameter int ADDR_WIDTH = bdpa_pkg::DEFAULT_ADDR_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bdpa_pkg::SIZE_WIDTH-1:0] csr_new_size,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [bdpa_pkg::BYTE_WIDTH-1:0] req_patch_byte,
   input  wire logic [bdpa_pkg::BYTE_WIDTH-1:0] req_old_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [bdpa_pkg::BYTE_WIDTH-1:0]      rsp_out_byte,
   output logic                                 rsp_out_valid,
   output logic [bdpa_pkg::OUT_ADDR_WIDTH-1:0]  rsp_old_address,
   output logic [1:0]                           rsp_status
);
   import bdpa_pkg::*;

   logic [SIZE_WIDTH-1:0]  new_size_ff;
   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [WORD_WIDTH-1:0]  shift_ff, shift_in;
   logic [LEN_WIDTH-1:0]   diff_ff, diff_in;
   logic [LEN_WIDTH-1:0]   extra_ff, extra_in;
   logic [ADDR_WIDTH-1:0]  seek_ff, seek_in;
   logic [SIZE_WIDTH-1:0]  new_pos_ff, new_pos_in;
   logic [ADDR_WIDTH-1:0]  old_pos_ff, old_pos_in;

   logic                   rsp_valid_ff;
   logic [BYTE_WIDTH-1:0]  out_byte_ff, out_byte_in;
   logic                   out_valid_ff, out_valid_in;
   logic [OUT_ADDR_WIDTH-1:0] old_addr_ff;
   status_type             status_ff, status_in;

   logic                   take;
   logic [WORD_WIDTH-1:0]  word;
   logic [WORD_WIDTH-2:0]  mag;
   logic                   word_bad;
   logic [LEN_WIDTH-1:0]   word_len;
   logic [ADDR_WIDTH-1:0]  mag_addr;
   logic [ADDR_WIDTH-1:0]  seek_val;
   logic [SIZE_WIDTH-1:0]  pos_inc;
   logic                   size_reached;
   logic                   inc_reached;
   logic                   diff_over;
   logic                   extra_over_now;
   logic                   extra_over_inc;
   logic [ADDR_WIDTH-1:0]  old_inc;
   logic [WORD_WIDTH-1:0]  old_wide;
   word_sel_type           word_sel;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   assign word     = {req_patch_byte, shift_ff[WORD_WIDTH-1:BYTE_WIDTH]};
   assign mag      = word[WORD_WIDTH-2:0];
   assign word_bad = (word[WORD_WIDTH-1] && (mag != '0)) || (mag[WORD_WIDTH-2:LEN_WIDTH] != '0);
   assign word_len = word_bad ? '0 : mag[LEN_WIDTH-1:0];
   assign mag_addr = mag[ADDR_WIDTH-1:0];
   assign seek_val = word[WORD_WIDTH-1] ? (~mag_addr + ADDR_WIDTH'(1)) : mag_addr;
   assign word_sel = word_sel_type'(count_ff[COUNT_WIDTH-1:3]);

   assign pos_inc        = new_pos_ff + SIZE_WIDTH'(1);
   assign size_reached   = new_pos_ff >= new_size_ff;
   assign inc_reached    = pos_inc >= new_size_ff;
   assign diff_over      = ({1'b0, new_pos_ff} + {2'b0, diff_ff}) > {1'b0, new_size_ff};
   assign extra_over_now = ({1'b0, new_pos_ff} + {2'b0, extra_ff}) > {1'b0, new_size_ff};
   assign extra_over_inc = ({1'b0, pos_inc} + {2'b0, extra_ff}) > {1'b0, new_size_ff};
   assign old_inc        = old_pos_ff + ADDR_WIDTH'(1);

   always_comb begin : next_state
      phase_in   = phase_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      diff_in    = diff_ff;
      extra_in   = extra_ff;
      seek_in    = seek_ff;
      new_pos_in = new_pos_ff;
      old_pos_in = old_pos_ff;
      unique case (phase_ff)
         PH_HEADER, PH_HEADER_BAD: begin
            if (phase_ff == PH_HEADER && count_ff == '0 && size_reached) begin
               phase_in = PH_DONE;
            end else begin
               shift_in = word;
               count_in = count_ff + COUNT_WIDTH'(1);
               if (count_ff[2:0] == 3'b111) begin
                  priority case (word_sel)
                     WORD_DIFF: begin
                        diff_in = word_len;
                        if (word_bad) phase_in = PH_HEADER_BAD;
                     end
                     WORD_EXTRA: begin
                        extra_in = word_len;
                        if (word_bad) phase_in = PH_HEADER_BAD;
                     end
                     default: begin
                        seek_in  = seek_val;
                        count_in = '0;
                        shift_in = '0;
                        priority if (phase_ff == PH_HEADER_BAD || diff_over) begin
                           phase_in = PH_ERROR;
                        end else if (diff_ff != '0) begin
                           phase_in = PH_DIFF;
                        end else if (extra_over_now) begin
                           phase_in = PH_ERROR;
                        end else if (extra_ff != '0) begin
                           phase_in = PH_EXTRA;
                        end else begin
                           old_pos_in = old_pos_ff + seek_val;
                           phase_in   = size_reached ? PH_DONE : PH_HEADER;
                        end
                     end
                  endcase
               end
            end
         end
         PH_DIFF: begin
            new_pos_in = pos_inc;
            old_pos_in = old_inc;
            diff_in    = diff_ff - LEN_WIDTH'(1);
            if (diff_ff == LEN_WIDTH'(1)) begin
               priority if (extra_over_inc) begin
                  phase_in = PH_ERROR;
               end else if (extra_ff != '0) begin
                  phase_in = PH_EXTRA;
               end else begin
                  old_pos_in = old_inc + seek_ff;
                  phase_in   = inc_reached ? PH_DONE : PH_HEADER;
               end
            end
         end
         PH_EXTRA: begin
            new_pos_in = pos_inc;
            extra_in   = extra_ff - LEN_WIDTH'(1);
            if (extra_ff == LEN_WIDTH'(1)) begin
               old_pos_in = old_pos_ff + seek_ff;
               phase_in   = inc_reached ? PH_DONE : PH_HEADER;
            end
         end
         PH_DONE, PH_ERROR: begin
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase
   end

   always_comb begin : outputs
      out_byte_in  = '0;
      out_valid_in = 1'b0;
      old_wide     = WORD_WIDTH'(old_pos_in);
      unique case (phase_ff)
         PH_DIFF: begin
            out_byte_in  = req_patch_byte + req_old_byte;
            out_valid_in = 1'b1;
         end
         PH_EXTRA: begin
            out_byte_in  = req_patch_byte;
            out_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
      unique case (phase_in)
         PH_DONE:  status_in = STATUS_DONE;
         PH_ERROR: status_in = STATUS_CORRUPT;
         default:  status_in = STATUS_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         new_size_ff  <= '0;
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         shift_ff     <= '0;
         diff_ff      <= '0;
         extra_ff     <= '0;
         seek_ff      <= '0;
         new_pos_ff   <= '0;
         old_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            new_size_ff <= csr_new_size;
         end
         if (take) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            shift_ff     <= shift_in;
            diff_ff      <= diff_in;
            extra_ff     <= extra_in;
            seek_ff      <= seek_in;
            new_pos_ff   <= new_pos_in;
            old_pos_ff   <= old_pos_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_byte_ff  <= out_byte_in;
         out_valid_ff <= out_valid_in;
         old_addr_ff  <= old_wide[OUT_ADDR_WIDTH-1:0];
         status_ff    <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_out_valid   = out_valid_ff;
   assign rsp_old_address = old_addr_ff;
   assign rsp_status      = status_ff;

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |=> phase_ff == PH_DONE)
      else $error("complete state left without reset");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |=> phase_ff == PH_ERROR)
      else $error("corrupt state left without reset");

   a_count_in_header: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> (phase_ff == PH_HEADER || phase_ff == PH_HEADER_BAD))
      else $error("control byte count nonzero outside header");

   a_old_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(old_pos_ff))
      else $error("old position moved without a request word");

endmodule

`default_nettype wire

// ===== bench/binary_delta_patch_applier_test.sv =====
module binary_delta_patch_applier_test;
   import bdpa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_WORDS = 1450;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_new_size;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_patch_byte;
   logic [7:0]  req_old_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_valid;
   logic [31:0] rsp_old_address;
   logic [1:0]  rsp_status;

   binary_delta_patch_applier dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_new_size    (csr_new_size),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_patch_byte  (req_patch_byte),
      .req_old_byte    (req_old_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_old_address (rsp_old_address),
      .rsp_status      (rsp_status)
   );

   typedef struct packed {
      bit [7:0]   data;
      bit         data_valid;
      bit [31:0]  address;
      status_type status;
   } rebuilt_word_type;

   class patch_scoreboard;
      bit [31:0]        size_limit;
      phase_type        ph;
      bit [4:0]         hdr_count;
      bit [63:0]        shift_word;
      bit [30:0]        diff_rem;
      bit [30:0]        extra_rem;
      bit [63:0]        seek_step;
      bit [31:0]        new_pos;
      bit [31:0]        old_pos;
      rebuilt_word_type rebuilt_words[$];
      int               accepted_words;
      int               failures;

      function new();
         size_limit = 0;
         ph = PH_HEADER;
         hdr_count = 0;
         shift_word = 0;
         diff_rem = 0;
         extra_rem = 0;
         seek_step = 0;
         new_pos = 0;
         old_pos = 0;
         accepted_words = 0;
         failures = 0;
      endfunction

      function bit decode_length(bit [63:0] w, output bit [30:0] len);
         if ((w[63] && w[62:0] != 0) || w[62:0] > 63'h7FFF_FFFF) begin
            len = 0;
            return 0;
         end
         len = w[30:0];
         return 1;
      endfunction

      function void finish_record();
         old_pos = old_pos + seek_step[31:0];
         ph = (new_pos >= size_limit) ? PH_DONE : PH_HEADER;
      endfunction

      function void finish_diff_run();
         if (33'(new_pos) + 33'(extra_rem) > 33'(size_limit)) begin
            ph = PH_ERROR;
         end else if (extra_rem != 0) begin
            ph = PH_EXTRA;
         end else begin
            finish_record();
         end
      endfunction

      function void take_control_byte(bit [7:0] b);
         shift_word = {b, shift_word[63:8]};
         hdr_count++;
         if (hdr_count[2:0] != 0)
            return;
         case (word_sel_type'(hdr_count[4:3] - 2'd1))
            WORD_DIFF: begin
               if (!decode_length(shift_word, diff_rem))
                  ph = PH_HEADER_BAD;
            end
            WORD_EXTRA: begin
               if (!decode_length(shift_word, extra_rem))
                  ph = PH_HEADER_BAD;
            end
            default: begin
               seek_step = shift_word[63] ? 64'd0 - {1'b0, shift_word[62:0]}
                                          : {1'b0, shift_word[62:0]};
               hdr_count = 0;
               shift_word = 0;
               if (ph == PH_HEADER_BAD ||
                   33'(new_pos) + 33'(diff_rem) > 33'(size_limit)) begin
                  ph = PH_ERROR;
               end else if (diff_rem != 0) begin
                  ph = PH_DIFF;
               end else begin
                  finish_diff_run();
               end
            end
         endcase
      endfunction

      function void apply_patch_byte(bit [7:0] pb, bit [7:0] ob);
         rebuilt_word_type w;
         w = '0;
         if (ph == PH_HEADER && hdr_count == 0 && new_pos >= size_limit) begin
            ph = PH_DONE;
         end else if (ph == PH_HEADER || ph == PH_HEADER_BAD) begin
            take_control_byte(pb);
         end else if (ph == PH_DIFF) begin
            w.data = pb + ob;
            w.data_valid = 1;
            new_pos++;
            old_pos++;
            diff_rem--;
            if (diff_rem == 0)
               finish_diff_run();
         end else if (ph == PH_EXTRA) begin
            w.data = pb;
            w.data_valid = 1;
            new_pos++;
            extra_rem--;
            if (extra_rem == 0)
               finish_record();
         end
         w.address = old_pos;
         if (ph == PH_DONE)
            w.status = STATUS_DONE;
         else if (ph == PH_ERROR)
            w.status = STATUS_CORRUPT;
         else
            w.status = STATUS_RUN;
         rebuilt_words.push_back(w);
         accepted_words++;
      endfunction

      function void check_rebuilt_word(logic [7:0] data, logic data_valid,
                                       logic [31:0] address, logic [1:0] status);
         rebuilt_word_type w;
         if (rebuilt_words.size() == 0) begin
            $error("response word with nothing outstanding");
            failures++;
            return;
         end
         w = rebuilt_words.pop_front();
         if (data !== w.data) begin
            $error("out_byte: expected %0h, got %0h", w.data, data);
            failures++;
         end
         if (data_valid !== w.data_valid) begin
            $error("out_valid: expected %0d, got %0d", w.data_valid, data_valid);
            failures++;
         end
         if (address !== w.address) begin
            $error("old_address: expected %0h, got %0h", w.address, address);
            failures++;
         end
         if (status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, status);
            failures++;
         end
      endfunction
   endclass

   patch_scoreboard sb;
   bit              steady;
   bit [7:0]        file_salt;
   int              cycle_count;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic bit [7:0] old_file_byte(bit [31:0] a);
      return (a[7:0] * 8'h9D) ^ a[15:8] ^ a[23:16] ^ a[31:24] ^ file_salt;
   endfunction

   function automatic int pick_length();
      case ($urandom_range(0, 9))
         0, 1: return 0;
         8: return $urandom_range(9, 24);
         9: return $urandom_range(25, 60);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   // zero sometimes goes out as a bare sign bit
   function automatic bit [63:0] encode_length(int len);
      if (len == 0 && $urandom_range(0, 3) == 0)
         return {1'b1, 63'd0};
      return 64'(len);
   endfunction

   function automatic bit [63:0] pick_seek();
      bit [62:0] mag;
      bit        neg;
      mag = 63'({$urandom, $urandom});
      neg = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
         0: return 64'd0;
         1: return {1'b1, 63'd0};
         2, 3: return {neg, 63'($urandom_range(1, 64))};
         4: return {1'b0, mag};
         5: return {1'b1, mag};
         6: return {neg, {63{1'b1}}};
         default: return {neg, 63'($urandom_range(1, 4096))};
      endcase
   endfunction

   function automatic bit [63:0] bad_length();
      case ($urandom_range(0, 3))
         0: return {1'b1, 63'($urandom_range(1, 255))};
         1: return {1'b0, 63'h8000_0000};
         2: return {1'b1, 63'({$urandom, $urandom}) | 63'd1};
         default: return {1'b0, 63'({$urandom, $urandom}) | 63'h8000_0000};
      endcase
   endfunction

   task automatic send_word(bit [7:0] pb, bit [7:0] ob);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_patch_byte <= pb;
      req_old_byte <= ob;
      do @(posedge clock); while (!req_ready);
      sb.apply_patch_byte(pb, ob);
   endtask

   task automatic send_control(bit [63:0] w);
      for (int i = 0; i < 8; i++)
         send_word(w[8*i +: 8], 8'($urandom));
   endtask

   task automatic send_record(bit [63:0] dw, bit [63:0] ew, bit [63:0] sw,
                              int dcount, int ecount);
      send_control(dw);
      send_control(ew);
      send_control(sw);
      repeat (dcount) send_word(8'($urandom), old_file_byte(sb.old_pos));
      repeat (ecount) send_word(8'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (sb.rebuilt_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_size(bit [31:0] v);
      wait_drained();
      csr_valid <= 1;
      csr_new_size <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.size_limit = v;
   endtask

   initial begin
      int stall;
      rsp_ready <= 0;
      wait (reset === 1'b0);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_rebuilt_word(rsp_out_byte, rsp_out_valid, rsp_old_address, rsp_status);
      end
   end

   initial begin
      int        d;
      int        e;
      int        k;
      bit [31:0] pos;
      sb = new();
      steady = 0;
      file_salt = 8'($urandom);
      reset <= 1;
      csr_valid <= 0;
      csr_new_size <= 0;
      req_valid <= 0;
      req_patch_byte <= 0;
      req_old_byte <= 0;
      repeat (4) @(posedge clock);
      reset <= 0;

      write_size(32'hFFFF_FFFF);

      // two diff bytes at the sum extremes, empty extra run, seek of minus zero
      send_control(64'd2);
      send_control({1'b1, 63'd0});
      send_control({1'b1, 63'd0});
      send_word(8'hFF, 8'hFF);
      send_word(8'h00, 8'h00);

      while (sb.accepted_words < RANDOM_WORDS) begin
         steady = ($urandom_range(0, 3) == 0);
         d = pick_length();
         e = pick_length();
         send_record(encode_length(d), encode_length(e), pick_seek(), d, e);
         case ($urandom_range(0, 11))
            0: write_size($urandom_range(0, 1) ? 32'hFFFF_FFFF
                          : sb.new_pos + 32'd4096 + $urandom_range(0, 32'h0FFF_FFFF));
            1: wait_drained();
            default: ;
         endcase
      end

      // one terminal case per run
      steady = 0;
      pos = sb.new_pos;
      d = $urandom_range(1, 8);
      e = $urandom_range(1, 8);
      case ($urandom_range(0, 6))
         0: begin
            d = pick_length() % 9;
            e = pick_length() % 9;
            write_size(pos + d + e);
            send_record(encode_length(d), encode_length(e), pick_seek(), d, e);
         end
         1: begin
            write_size($urandom_range(0, 1) ? pos : 32'd0);
            send_record(64'(d), 64'(e), pick_seek(), d, e);
         end
         2: send_record(bad_length(), encode_length(e), pick_seek(), d, e);
         3: send_record(encode_length(d), bad_length(), pick_seek(), d, e);
         4: begin
            k = $urandom_range(0, 20);
            write_size(pos + k);
            d = $urandom_range(0, 1) ? 32'h7FFF_FFFF : k + 1 + $urandom_range(0, 20);
            send_record(64'(d), encode_length(0), pick_seek(), k + 3, 0);
         end
         5: begin
            write_size(pos + d + e - 1);
            send_record(64'(d), 64'(e), pick_seek(), d, e);
         end
         default: begin
            write_size(pos + e - 1);
            send_record(encode_length(0), 64'(e), pick_seek(), 0, e);
         end
      endcase

      // stopped for good: later size writes must not restart it
      repeat (16) send_word(8'($urandom), 8'($urandom));
      write_size(32'd0);
      repeat (8) send_word(8'($urandom), 8'($urandom));
      write_size(32'hFFFF_FFFF);
      repeat (8) send_word(8'($urandom), 8'($urandom));
      wait_drained();
      repeat (8) @(posedge clock);

      if (sb.failures == 0 && sb.rebuilt_words.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
